@@ src/mpbm_pkg.sv @@
// shared constants, codes and state type for the multi-pattern byte matcher
// no dependencies
package mpbm_pkg;

    localparam int MAX_STATES      = 256;
    localparam int MAX_PATTERNS    = 32;
    localparam int MAX_PATTERN_LEN = 255;
    localparam int POSITION_BITS   = 16;

    localparam int SYM_W   = 8;
    localparam int ST_W    = $clog2(MAX_STATES);
    localparam int NFS_W   = ST_W + 1;
    localparam int GOTO_AW = ST_W + SYM_W;
    localparam int PID_W   = $clog2(MAX_PATTERNS);
    localparam int CNT_W   = PID_W + 1;
    localparam int LIST_AW = ST_W + PID_W;
    localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
    localparam int POS_W   = POSITION_BITS;
    localparam int START_W = 17;
    localparam int ID_W    = 5;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    localparam logic [KIND_W-1:0] KIND_OK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd2;

    localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_ADD_RD,
        S_END_RD,
        S_BLD_SCAN,
        S_BLD_SCAN_RD,
        S_FW_RD,
        S_FW_CHK,
        S_FW_FL,
        S_SL_OC,
        S_SL_CP_RD,
        S_SL_CP_WR,
        S_SL_FCNT,
        S_SL_AP_RD,
        S_SL_AP_WR,
        S_SL_DONE,
        S_BLD_NEXT,
        S_BLD_DEQ,
        S_BLD_FR,
        S_SR_CHK,
        S_SR_FL,
        S_SR_CNT,
        S_SR_ID,
        S_SR_LEN
    } t_state;

endpackage

@@ src/multi_pattern_byte_matcher.sv @@
// top level of the multi-pattern byte matcher: sequencer and trie memories
// depends on mpbm_pkg and mpbm_ram
//
// usage
//   commands enter on i_cmd/i_data_byte/i_text_start, transferred at a clock
//   edge with start high and busy low. cmd 0 adds a pattern byte, 1 closes
//   the pattern, 2 builds failure links, 3 feeds one text byte.
//   every command returns one or more results, each shown for one cycle with
//   o_valid high; o_last marks the final result of a command. the receiver
//   cannot stall, so results simply stream out as they are produced.
// sequencing
//   search byte: one goto read, then a failure link read and a goto read
//   per link walked, then an id read and a length read per match. build:
//   every goto entry of every reached state is read (256 per state), plus
//   the failure walks and list copies, one list entry at a time. the goto
//   memory has one read port.
// reset
//   i_rst_n is synchronous; afterwards a clearing pass writes every goto
//   entry to no transition, with busy high throughout.
//
module multi_pattern_byte_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mpbm_pkg::CMD_W-1:0]          i_cmd,
    input  logic [mpbm_pkg::SYM_W-1:0]          i_data_byte,
    input  logic                                i_text_start,
    output logic                                o_valid,
    output logic [mpbm_pkg::KIND_W-1:0]         o_kind,
    output logic [mpbm_pkg::ID_W-1:0]           o_pattern_id,
    output logic signed [mpbm_pkg::START_W-1:0] o_start_pos,
    output logic [mpbm_pkg::POS_W-1:0]          o_end_pos,
    output logic                                o_last
);

    import mpbm_pkg::*;

    localparam logic [CNT_W-1:0] MAX_PAT_C = CNT_W'(MAX_PATTERNS);
    localparam logic [NFS_W-1:0] MAX_ST_C  = NFS_W'(MAX_STATES);
    localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_PATTERN_LEN);
    localparam logic [POS_W-1:0] POS_MAX_C = {POS_W{1'b1}};

    // sequencer registers
    t_state             r_state, n_state;
    logic [GOTO_AW-1:0] r_clr, n_clr;
    logic [SYM_W-1:0]   r_byte, n_byte;
    // pattern entry
    logic [NFS_W-1:0]   r_nfs, n_nfs;
    logic [ST_W-1:0]    r_cursor, n_cursor;
    logic               r_div, n_div;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_failed, n_failed;
    logic [CNT_W-1:0]   r_stored, n_stored;
    // search
    logic [ST_W-1:0]    r_sstate, n_sstate;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_muted, n_muted;
    logic [POS_W-1:0]   r_end, n_end;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    // shared walk pointer (failure walk in build and search)
    logic [ST_W-1:0]    r_cur, n_cur;
    // build
    logic [ST_W-1:0]    r_r, n_r;
    logic [ST_W-1:0]    r_fr, n_fr;
    logic [SYM_W-1:0]   r_a, n_a;
    logic               r_root, n_root;
    logic [NFS_W-1:0]   r_head, n_head;
    logic [NFS_W-1:0]   r_tail, n_tail;
    logic [ST_W-1:0]    r_s, n_s;
    logic [ST_W-1:0]    r_f, n_f;
    logic [CNT_W-1:0]   r_c, n_c;
    logic [CNT_W-1:0]   r_co, n_co;
    logic [CNT_W-1:0]   r_cf, n_cf;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [PID_W-1:0]   r_id, n_id;

    // result register
    logic                r_ovalid, n_ovalid;
    logic [KIND_W-1:0]   r_okind, n_okind;
    logic [ID_W-1:0]     r_oid, n_oid;
    logic [START_W-1:0]  r_ostart, n_ostart;
    logic [POS_W-1:0]    r_oend, n_oend;
    logic                r_olast, n_olast;

    // memory ports
    logic               goto_we;
    logic [GOTO_AW-1:0] goto_waddr, goto_raddr;
    logic [ST_W-1:0]    goto_wdata, goto_rdata;
    logic               fail_we;
    logic [ST_W-1:0]    fail_waddr, fail_raddr, fail_wdata, fail_rdata;
    logic               mcnt_we;
    logic [ST_W-1:0]    mcnt_waddr, mcnt_raddr;
    logic [CNT_W-1:0]   mcnt_wdata, mcnt_rdata;
    logic               ocnt_we;
    logic [ST_W-1:0]    ocnt_waddr, ocnt_raddr;
    logic [CNT_W-1:0]   ocnt_wdata, ocnt_rdata;
    logic               mlist_we;
    logic [LIST_AW-1:0] mlist_waddr, mlist_raddr;
    logic [PID_W-1:0]   mlist_wdata, mlist_rdata;
    logic               olist_we;
    logic [LIST_AW-1:0] olist_waddr, olist_raddr;
    logic [PID_W-1:0]   olist_wdata, olist_rdata;
    logic               plen_we;
    logic [PID_W-1:0]   plen_waddr, plen_raddr;
    logic [LEN_W-1:0]   plen_wdata, plen_rdata;
    logic               bfsq_we;
    logic [ST_W-1:0]    bfsq_waddr, bfsq_raddr, bfsq_wdata, bfsq_rdata;

    // helpers
    logic [POS_W-1:0]   p0;
    logic               muted_now;
    logic [ST_W-1:0]    sr_from;
    logic [CNT_W-1:0]   cnt_sat;
    logic [CNT_W-1:0]   k_inc;

    // goto: {state, byte} -> next state, zero is no transition
    mpbm_ram #(.AW(GOTO_AW), .DW(ST_W)) u_goto (
        .i_clk(i_clk), .i_we(goto_we), .i_waddr(goto_waddr), .i_wdata(goto_wdata),
        .i_raddr(goto_raddr), .o_rdata(goto_rdata)
    );
    mpbm_ram #(.AW(ST_W), .DW(ST_W)) u_fail (
        .i_clk(i_clk), .i_we(fail_we), .i_waddr(fail_waddr), .i_wdata(fail_wdata),
        .i_raddr(fail_raddr), .o_rdata(fail_rdata)
    );
    // full match list length per state
    mpbm_ram #(.AW(ST_W), .DW(CNT_W)) u_mcnt (
        .i_clk(i_clk), .i_we(mcnt_we), .i_waddr(mcnt_waddr), .i_wdata(mcnt_wdata),
        .i_raddr(mcnt_raddr), .o_rdata(mcnt_rdata)
    );
    // own pattern count per state
    mpbm_ram #(.AW(ST_W), .DW(CNT_W)) u_ocnt (
        .i_clk(i_clk), .i_we(ocnt_we), .i_waddr(ocnt_waddr), .i_wdata(ocnt_wdata),
        .i_raddr(ocnt_raddr), .o_rdata(ocnt_rdata)
    );
    mpbm_ram #(.AW(LIST_AW), .DW(PID_W)) u_mlist (
        .i_clk(i_clk), .i_we(mlist_we), .i_waddr(mlist_waddr), .i_wdata(mlist_wdata),
        .i_raddr(mlist_raddr), .o_rdata(mlist_rdata)
    );
    mpbm_ram #(.AW(LIST_AW), .DW(PID_W)) u_olist (
        .i_clk(i_clk), .i_we(olist_we), .i_waddr(olist_waddr), .i_wdata(olist_wdata),
        .i_raddr(olist_raddr), .o_rdata(olist_rdata)
    );
    mpbm_ram #(.AW(PID_W), .DW(LEN_W)) u_plen (
        .i_clk(i_clk), .i_we(plen_we), .i_waddr(plen_waddr), .i_wdata(plen_wdata),
        .i_raddr(plen_raddr), .o_rdata(plen_rdata)
    );
    // breadth-first work queue for the build
    mpbm_ram #(.AW(ST_W), .DW(ST_W)) u_bfsq (
        .i_clk(i_clk), .i_we(bfsq_we), .i_waddr(bfsq_waddr), .i_wdata(bfsq_wdata),
        .i_raddr(bfsq_raddr), .o_rdata(bfsq_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_nfs    <= NFS_W'(1);
            r_cursor <= '0;
            r_div    <= 1'b0;
            r_len    <= '0;
            r_failed <= 1'b0;
            r_stored <= '0;
            r_sstate <= '0;
            r_pos    <= '0;
            r_muted  <= 1'b0;
            r_root   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_nfs    <= n_nfs;
            r_cursor <= n_cursor;
            r_div    <= n_div;
            r_len    <= n_len;
            r_failed <= n_failed;
            r_stored <= n_stored;
            r_sstate <= n_sstate;
            r_pos    <= n_pos;
            r_muted  <= n_muted;
            r_root   <= n_root;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ovalid <= n_ovalid;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_end    <= n_end;
        r_cnt    <= n_cnt;
        r_cur    <= n_cur;
        r_r      <= n_r;
        r_fr     <= n_fr;
        r_a      <= n_a;
        r_s      <= n_s;
        r_f      <= n_f;
        r_c      <= n_c;
        r_co     <= n_co;
        r_cf     <= n_cf;
        r_k      <= n_k;
        r_id     <= n_id;
        r_okind  <= n_okind;
        r_oid    <= n_oid;
        r_ostart <= n_ostart;
        r_oend   <= n_oend;
        r_olast  <= n_olast;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_pattern_id = r_oid;
    assign o_start_pos  = $signed(r_ostart);
    assign o_end_pos    = r_oend;
    assign o_last       = r_olast;

    // text byte position for an incoming search byte
    assign p0        = i_text_start ? '0 : r_pos;
    assign muted_now = i_text_start ? (i_data_byte == SYM_SPACE || i_data_byte == SYM_NUL)
                                    : r_muted;
    assign sr_from   = i_text_start ? '0 : r_sstate;
    assign cnt_sat   = (mcnt_rdata > MAX_PAT_C) ? MAX_PAT_C : mcnt_rdata;
    assign k_inc     = r_k + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_byte   = r_byte;
        n_nfs    = r_nfs;
        n_cursor = r_cursor;
        n_div    = r_div;
        n_len    = r_len;
        n_failed = r_failed;
        n_stored = r_stored;
        n_sstate = r_sstate;
        n_pos    = r_pos;
        n_muted  = r_muted;
        n_end    = r_end;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_r      = r_r;
        n_fr     = r_fr;
        n_a      = r_a;
        n_root   = r_root;
        n_head   = r_head;
        n_tail   = r_tail;
        n_s      = r_s;
        n_f      = r_f;
        n_c      = r_c;
        n_co     = r_co;
        n_cf     = r_cf;
        n_k      = r_k;
        n_id     = r_id;

        n_ovalid = 1'b0;
        n_okind  = KIND_OK;
        n_oid    = '0;
        n_ostart = '0;
        n_oend   = '0;
        n_olast  = 1'b1;

        goto_we = 1'b0;  goto_waddr = '0;  goto_wdata = '0;  goto_raddr = '0;
        fail_we = 1'b0;  fail_waddr = '0;  fail_wdata = '0;  fail_raddr = '0;
        mcnt_we = 1'b0;  mcnt_waddr = '0;  mcnt_wdata = '0;  mcnt_raddr = '0;
        ocnt_we = 1'b0;  ocnt_waddr = '0;  ocnt_wdata = '0;  ocnt_raddr = '0;
        mlist_we = 1'b0; mlist_waddr = '0; mlist_wdata = '0; mlist_raddr = '0;
        olist_we = 1'b0; olist_waddr = '0; olist_wdata = '0; olist_raddr = '0;
        plen_we = 1'b0;  plen_waddr = '0;  plen_wdata = '0;  plen_raddr = '0;
        bfsq_we = 1'b0;  bfsq_waddr = '0;  bfsq_wdata = '0;  bfsq_raddr = '0;

        unique case (r_state)
            // clearing pass: goto entries, and the count tables on the way
            S_CLR: begin
                goto_we    = 1'b1;
                goto_waddr = r_clr;
                if (r_clr[GOTO_AW-1:ST_W] == '0) begin
                    mcnt_we    = 1'b1;
                    mcnt_waddr = r_clr[ST_W-1:0];
                    ocnt_we    = 1'b1;
                    ocnt_waddr = r_clr[ST_W-1:0];
                end
                n_clr = r_clr + GOTO_AW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_byte = i_data_byte;
                    case (i_cmd)
                        CMD_ADD: begin
                            if (r_failed || i_data_byte == SYM_NUL || r_len >= MAX_LEN_C) begin
                                n_failed = 1'b1;
                                n_ovalid = 1'b1;
                                n_okind  = KIND_ERR;
                            end else begin
                                n_len = r_len + LEN_W'(1);
                                if (!r_div || i_data_byte != SYM_SPACE) begin
                                    goto_raddr = {r_cursor, i_data_byte};
                                    n_state    = S_ADD_RD;
                                end else begin
                                    // space after divergence: counted, no state
                                    n_ovalid = 1'b1;
                                end
                            end
                        end
                        CMD_END: begin
                            if (r_failed || r_len == '0 || r_stored >= MAX_PAT_C) begin
                                n_ovalid = 1'b1;
                                n_okind  = KIND_ERR;
                                n_cursor = '0;
                                n_div    = 1'b0;
                                n_len    = '0;
                                n_failed = 1'b0;
                            end else begin
                                plen_we    = 1'b1;
                                plen_waddr = r_stored[PID_W-1:0];
                                plen_wdata = r_len;
                                n_id       = r_stored[PID_W-1:0];
                                n_stored   = r_stored + CNT_W'(1);
                                ocnt_raddr = r_cursor;
                                n_state    = S_END_RD;
                            end
                        end
                        CMD_BUILD: begin
                            fail_we = 1'b1;
                            n_r     = '0;
                            n_a     = '0;
                            n_root  = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_state = S_BLD_SCAN;
                        end
                        default: begin
                            n_end = p0;
                            n_pos = (p0 == POS_MAX_C) ? p0 : p0 + POS_W'(1);
                            if (i_text_start) begin
                                n_sstate = '0;
                                n_muted  = muted_now;
                            end
                            if (muted_now) begin
                                n_ovalid = 1'b1;
                                n_oend   = p0;
                            end else begin
                                n_cur      = sr_from;
                                goto_raddr = {sr_from, i_data_byte};
                                n_state    = S_SR_CHK;
                            end
                        end
                    endcase
                end
            end

            S_ADD_RD: begin
                n_state  = S_IDLE;
                n_ovalid = 1'b1;
                if (!r_div && goto_rdata != '0) begin
                    n_cursor = goto_rdata;
                end else begin
                    n_div = 1'b1;
                    if (r_byte == SYM_SPACE) begin
                        n_okind = KIND_OK;
                    end else if (r_nfs >= MAX_ST_C) begin
                        n_failed = 1'b1;
                        n_okind  = KIND_ERR;
                    end else begin
                        // new trie state, an existing transition wins
                        fail_we    = 1'b1;
                        fail_waddr = r_nfs[ST_W-1:0];
                        mcnt_we    = 1'b1;
                        mcnt_waddr = r_nfs[ST_W-1:0];
                        ocnt_we    = 1'b1;
                        ocnt_waddr = r_nfs[ST_W-1:0];
                        if (goto_rdata == '0) begin
                            goto_we    = 1'b1;
                            goto_waddr = {r_cursor, r_byte};
                            goto_wdata = r_nfs[ST_W-1:0];
                        end
                        n_cursor = r_nfs[ST_W-1:0];
                        n_nfs    = r_nfs + NFS_W'(1);
                    end
                end
            end

            S_END_RD: begin
                if (ocnt_rdata < MAX_PAT_C) begin
                    olist_we    = 1'b1;
                    olist_waddr = {r_cursor, ocnt_rdata[PID_W-1:0]};
                    olist_wdata = r_id;
                    ocnt_we     = 1'b1;
                    ocnt_waddr  = r_cursor;
                    ocnt_wdata  = ocnt_rdata + CNT_W'(1);
                end
                n_ovalid = 1'b1;
                n_oid    = ID_W'(r_id);
                n_cursor = '0;
                n_div    = 1'b0;
                n_len    = '0;
                n_failed = 1'b0;
                n_state  = S_IDLE;
            end

            S_BLD_SCAN: begin
                goto_raddr = {r_r, r_a};
                n_state    = S_BLD_SCAN_RD;
            end

            S_BLD_SCAN_RD: begin
                if (goto_rdata == '0) begin
                    n_a     = r_a + SYM_W'(1);
                    n_state = (&r_a) ? S_BLD_NEXT : S_BLD_SCAN;
                end else begin
                    bfsq_we    = 1'b1;
                    bfsq_waddr = r_tail[ST_W-1:0];
                    bfsq_wdata = goto_rdata;
                    n_tail     = r_tail + NFS_W'(1);
                    n_s        = goto_rdata;
                    if (r_root) begin
                        // first level fails to the root
                        fail_we    = 1'b1;
                        fail_waddr = goto_rdata;
                        n_f        = '0;
                        ocnt_raddr = goto_rdata;
                        n_state    = S_SL_OC;
                    end else begin
                        n_cur   = r_fr;
                        n_state = S_FW_RD;
                    end
                end
            end

            S_FW_RD: begin
                goto_raddr = {r_cur, r_a};
                n_state    = S_FW_CHK;
            end

            S_FW_CHK: begin
                if (goto_rdata != '0 || r_cur == '0) begin
                    fail_we    = 1'b1;
                    fail_waddr = r_s;
                    fail_wdata = goto_rdata;
                    n_f        = goto_rdata;
                    ocnt_raddr = r_s;
                    n_state    = S_SL_OC;
                end else begin
                    fail_raddr = r_cur;
                    n_state    = S_FW_FL;
                end
            end

            S_FW_FL: begin
                n_cur   = fail_rdata;
                n_state = S_FW_RD;
            end

            // match list = own list, then the failure target's list
            S_SL_OC: begin
                n_co    = ocnt_rdata;
                n_k     = '0;
                n_state = S_SL_CP_RD;
            end

            S_SL_CP_RD: begin
                if (r_k < r_co) begin
                    olist_raddr = {r_s, r_k[PID_W-1:0]};
                    n_state     = S_SL_CP_WR;
                end else begin
                    n_c = r_co;
                    if (r_f != '0) begin
                        mcnt_raddr = r_f;
                        n_state    = S_SL_FCNT;
                    end else begin
                        n_state = S_SL_DONE;
                    end
                end
            end

            S_SL_CP_WR: begin
                mlist_we    = 1'b1;
                mlist_waddr = {r_s, r_k[PID_W-1:0]};
                mlist_wdata = olist_rdata;
                n_k         = k_inc;
                n_state     = S_SL_CP_RD;
            end

            S_SL_FCNT: begin
                n_cf    = mcnt_rdata;
                n_k     = '0;
                n_state = S_SL_AP_RD;
            end

            S_SL_AP_RD: begin
                if (r_k < r_cf && r_c < MAX_PAT_C) begin
                    mlist_raddr = {r_f, r_k[PID_W-1:0]};
                    n_state     = S_SL_AP_WR;
                end else begin
                    n_state = S_SL_DONE;
                end
            end

            S_SL_AP_WR: begin
                mlist_we    = 1'b1;
                mlist_waddr = {r_s, r_c[PID_W-1:0]};
                mlist_wdata = mlist_rdata;
                n_c         = r_c + CNT_W'(1);
                n_k         = k_inc;
                n_state     = S_SL_AP_RD;
            end

            S_SL_DONE: begin
                mcnt_we    = 1'b1;
                mcnt_waddr = r_s;
                mcnt_wdata = r_c;
                n_a        = r_a + SYM_W'(1);
                n_state    = (&r_a) ? S_BLD_NEXT : S_BLD_SCAN;
            end

            S_BLD_NEXT: begin
                n_root = 1'b0;
                if (r_head < r_tail) begin
                    bfsq_raddr = r_head[ST_W-1:0];
                    n_head     = r_head + NFS_W'(1);
                    n_state    = S_BLD_DEQ;
                end else begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_BLD_DEQ: begin
                n_r        = bfsq_rdata;
                fail_raddr = bfsq_rdata;
                n_a        = '0;
                n_state    = S_BLD_FR;
            end

            S_BLD_FR: begin
                n_fr    = fail_rdata;
                n_state = S_BLD_SCAN;
            end

            // search: goto, else follow failure links
            S_SR_CHK: begin
                if (goto_rdata != '0) begin
                    n_sstate   = goto_rdata;
                    mcnt_raddr = goto_rdata;
                    n_state    = S_SR_CNT;
                end else if (r_cur == '0) begin
                    n_sstate = '0;
                    n_ovalid = 1'b1;
                    n_oend   = r_end;
                    n_state  = S_IDLE;
                end else begin
                    fail_raddr = r_cur;
                    n_state    = S_SR_FL;
                end
            end

            S_SR_FL: begin
                n_cur      = fail_rdata;
                goto_raddr = {fail_rdata, r_byte};
                n_state    = S_SR_CHK;
            end

            S_SR_CNT: begin
                if (cnt_sat == '0) begin
                    n_ovalid = 1'b1;
                    n_oend   = r_end;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt       = cnt_sat;
                    n_k         = '0;
                    mlist_raddr = {r_sstate, {PID_W{1'b0}}};
                    n_state     = S_SR_ID;
                end
            end

            S_SR_ID: begin
                n_id       = mlist_rdata;
                plen_raddr = mlist_rdata;
                n_state    = S_SR_LEN;
            end

            S_SR_LEN: begin
                n_ovalid = 1'b1;
                n_okind  = KIND_MATCH;
                n_oid    = ID_W'(r_id);
                n_ostart = {{(START_W-POS_W){1'b0}}, r_end}
                         - START_W'(plen_rdata) + START_W'(1);
                n_oend   = r_end;
                n_olast  = (k_inc == r_cnt);
                if (k_inc == r_cnt) begin
                    n_state = S_IDLE;
                end else begin
                    n_k         = k_inc;
                    mlist_raddr = {r_sstate, k_inc[PID_W-1:0]};
                    n_state     = S_SR_ID;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/mpbm_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mpbm_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ dv/mpbm_match_checker.sv @@
// checker for the multi-pattern byte matcher: watches command and result transfers
// keeps its own trie, failure links and match lists; depends on mpbm_pkg
module mpbm_match_checker
    import mpbm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic [SYM_W-1:0]          i_data_byte,
    input  logic                      i_text_start,
    input  logic                      o_valid,
    input  logic [KIND_W-1:0]         o_kind,
    input  logic [ID_W-1:0]           o_pattern_id,
    input  logic signed [START_W-1:0] o_start_pos,
    input  logic [POS_W-1:0]          o_end_pos,
    input  logic                      o_last,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [START_W-1:0] spos;
        logic [POS_W-1:0]   epos;
        logic               last;
    } report_t;

    report_t     expected_reports[$];
    int unsigned trie_next[MAX_STATES*256];
    int unsigned fail_to[MAX_STATES];
    int unsigned hit_cnt[MAX_STATES];
    int unsigned hit_ids[MAX_STATES*MAX_PATTERNS];
    int unsigned own_cnt[MAX_STATES];
    int unsigned own_ids[MAX_STATES*MAX_PATTERNS];
    int unsigned pat_len[MAX_PATTERNS];
    int unsigned bfs[MAX_STATES];
    int unsigned n_pat, free_st, cursor, plen, walk_st;
    bit          diverged, failed, muted;
    longint      tpos;
    int          errs;

    function automatic void clear_trie();
        for (int i = 0; i < MAX_STATES*256; i++) trie_next[i] = 0;
        for (int i = 0; i < MAX_STATES; i++) begin
            fail_to[i] = 0; hit_cnt[i] = 0; own_cnt[i] = 0;
        end
        n_pat = 0; free_st = 1; cursor = 0; plen = 0; walk_st = 0;
        diverged = 0; failed = 0; muted = 0; tpos = 0;
    endfunction

    function automatic void push(logic [KIND_W-1:0] k, int unsigned id, longint sp,
                                 longint ep, bit l);
        report_t r;
        r.kind = k; r.id = id[ID_W-1:0]; r.spos = sp[START_W-1:0];
        r.epos = ep[POS_W-1:0]; r.last = l;
        expected_reports.push_back(r);
    endfunction

    function automatic logic [KIND_W-1:0] grow_pattern(int unsigned b);
        int unsigned t, n;
        if (failed) return KIND_ERR;
        if (b == SYM_NUL || plen >= MAX_PATTERN_LEN) begin
            failed = 1;
            return KIND_ERR;
        end
        plen++;
        if (!diverged) begin
            t = trie_next[cursor*256 + b];
            if (t != 0) begin
                cursor = t;
                return KIND_OK;
            end
            diverged = 1;
        end
        if (b == SYM_SPACE) return KIND_OK;
        if (free_st >= MAX_STATES) begin
            failed = 1;
            return KIND_ERR;
        end
        n = free_st++;
        fail_to[n] = 0; hit_cnt[n] = 0; own_cnt[n] = 0;
        // an existing edge keeps priority over the new branch
        if (trie_next[cursor*256 + b] == 0) trie_next[cursor*256 + b] = n;
        cursor = n;
        return KIND_OK;
    endfunction

    function automatic void merge_hits(int unsigned s, int unsigned f);
        int unsigned c;
        c = own_cnt[s];
        for (int k = 0; k < c; k++) hit_ids[s*MAX_PATTERNS + k] = own_ids[s*MAX_PATTERNS + k];
        if (f != 0)
            for (int k = 0; k < hit_cnt[f] && c < MAX_PATTERNS; k++)
                hit_ids[s*MAX_PATTERNS + c++] = hit_ids[f*MAX_PATTERNS + k];
        hit_cnt[s] = c;
    endfunction

    function automatic void link_failures();
        int unsigned head, tail, r, s, p, f, t;
        head = 0; tail = 0;
        fail_to[0] = 0;
        for (int a = 0; a < 256; a++) begin
            s = trie_next[a];
            if (s != 0) begin
                fail_to[s] = 0;
                merge_hits(s, 0);
                if (tail < MAX_STATES) bfs[tail++] = s;
            end
        end
        while (head < tail) begin
            r = bfs[head++];
            for (int a = 0; a < 256; a++) begin
                s = trie_next[r*256 + a];
                if (s != 0) begin
                    if (tail < MAX_STATES) bfs[tail++] = s;
                    p = fail_to[r];
                    f = 0;
                    for (int g = 0; g <= MAX_STATES; g++) begin
                        t = trie_next[p*256 + a];
                        if (t != 0) begin
                            f = t;
                            break;
                        end
                        if (p == 0) break;
                        p = fail_to[p];
                    end
                    fail_to[s] = f;
                    merge_hits(s, f);
                end
            end
        end
    endfunction

    function automatic void predict_command(logic [CMD_W-1:0] c, int unsigned b, bit ts);
        int unsigned s, t, cnt, id;
        longint      ep;
        bit          found, bad;
        found = 0;
        case (c)
            CMD_ADD: begin
                push(grow_pattern(b), 0, 0, 0, 1);
            end
            CMD_END: begin
                bad = failed || plen == 0 || n_pat >= MAX_PATTERNS;
                id = 0;
                if (!bad) begin
                    id = n_pat++;
                    pat_len[id] = plen;
                    if (own_cnt[cursor] < MAX_PATTERNS)
                        own_ids[cursor*MAX_PATTERNS + own_cnt[cursor]++] = id;
                end
                cursor = 0; diverged = 0; plen = 0; failed = 0;
                push(bad ? KIND_ERR : KIND_OK, id, 0, 0, 1);
            end
            CMD_BUILD: begin
                link_failures();
                push(KIND_OK, 0, 0, 0, 1);
            end
            default: begin
                if (ts) begin
                    tpos = 0; walk_st = 0;
                    muted = (b == SYM_SPACE || b == SYM_NUL);
                end
                ep = tpos;
                if (tpos < (64'd1 << POSITION_BITS) - 1) tpos++;
                if (muted) begin
                    push(KIND_OK, 0, 0, ep, 1);
                    return;
                end
                s = walk_st;
                for (int g = 0; g <= MAX_STATES; g++) begin
                    t = trie_next[s*256 + b];
                    if (t != 0) begin
                        s = t; found = 1;
                        break;
                    end
                    if (s == 0) break;
                    s = fail_to[s];
                end
                if (!found) s = 0;
                walk_st = s;
                cnt = found ? hit_cnt[s] : 0;
                if (cnt > MAX_PATTERNS) cnt = MAX_PATTERNS;
                if (cnt == 0) push(KIND_OK, 0, 0, ep, 1);
                for (int k = 0; k < cnt; k++) begin
                    id = hit_ids[s*MAX_PATTERNS + k] % MAX_PATTERNS;
                    push(KIND_MATCH, id, ep - longint'(pat_len[id]) + 1, ep, k + 1 == cnt);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        report_t want;
        if (!i_rst_n) begin
            clear_trie();
            expected_reports.delete();
            errs = 0;
        end else begin
            if (start && !busy) predict_command(i_cmd, i_data_byte, i_text_start);
            if (o_valid) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result kind=%0d id=%0d", o_kind, o_pattern_id);
                    errs++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind); errs++;
                    end
                    if (o_pattern_id !== want.id) begin
                        $error("pattern_id: expected %0d, got %0d", want.id, o_pattern_id);
                        errs++;
                    end
                    if (o_start_pos !== want.spos) begin
                        $error("start_pos: expected %0d, got %0d",
                               $signed(want.spos), o_start_pos);
                        errs++;
                    end
                    if (o_end_pos !== want.epos) begin
                        $error("end_pos: expected %0d, got %0d", want.epos, o_end_pos);
                        errs++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last); errs++;
                    end
                end
            end
        end
    end

    assign o_errors  = errs;
    assign o_pending = expected_reports.size();

endmodule

@@ dv/tb_multi_pattern_byte_matcher.sv @@
// top of the matcher testbench: clock, reset, command stimulus and verdict
// depends on mpbm_pkg, multi_pattern_byte_matcher and mpbm_match_checker
module tb_multi_pattern_byte_matcher;
    import mpbm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // budget covers the clearing pass, a handful of builds and a 64k-byte text
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic                      i_clk, i_rst_n, start, busy;
    logic [CMD_W-1:0]          i_cmd;
    logic [SYM_W-1:0]          i_data_byte;
    logic                      i_text_start;
    logic                      o_valid, o_last;
    logic [KIND_W-1:0]         o_kind;
    logic [ID_W-1:0]           o_pattern_id;
    logic signed [START_W-1:0] o_start_pos;
    logic [POS_W-1:0]          o_end_pos;
    int                        errors, pending;
    longint                    cycles;
    int                        idle_pct;

    multi_pattern_byte_matcher i_dut (.*);
    mpbm_match_checker i_checker (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // global watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one command transfer, preceded by random idle cycles
    task automatic issue(logic [CMD_W-1:0] c, logic [SYM_W-1:0] b, logic ts);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1; i_cmd <= c; i_data_byte <= b; i_text_start <= ts;
        do @(posedge i_clk); while (busy);
    endtask

    // whole pattern from a string, closed with an end command
    task automatic add_word(string w);
        for (int i = 0; i < w.len(); i++) issue(CMD_ADD, w[i], 1'b0);
        issue(CMD_END, 8'h00, 1'b0);
    endtask

    task automatic search_text(string w);
        for (int i = 0; i < w.len(); i++) issue(CMD_SEARCH, w[i], i == 0);
    endtask

    // small alphabet keeps random texts hitting random patterns
    function automatic logic [SYM_W-1:0] pick_sym();
        int r;
        r = $urandom_range(99);
        if (r < 4) return SYM_SPACE;
        if (r < 7) return $urandom_range(255);
        return "a" + $urandom_range(3);
    endfunction

    initial begin
        logic [CMD_W-1:0] c;
        int               n;
        cycles = 0; idle_pct = 0;
        start = 0; i_cmd = CMD_ADD; i_data_byte = 0; i_text_start = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: search before any build, empty end
        issue(CMD_SEARCH, "h", 1'b1);
        issue(CMD_END, 8'h00, 1'b0);
        add_word("he"); add_word("she"); add_word("his"); add_word("hers");
        // zero byte fails the pattern, later bytes and the end are errors too
        issue(CMD_ADD, "a", 1'b0); issue(CMD_ADD, 8'h00, 1'b0);
        issue(CMD_ADD, 8'hff, 1'b0); issue(CMD_END, 8'h00, 1'b0);
        add_word("   ");   // spaces only: stored at the root
        add_word("h e");   // skipped space then goto collision on 'e'
        // over-long pattern: one state, then spaces past the length cap
        issue(CMD_ADD, "q", 1'b0);
        for (int i = 0; i < MAX_PATTERN_LEN; i++) issue(CMD_ADD, SYM_SPACE, 1'b0);
        issue(CMD_END, 8'h00, 1'b0);
        issue(CMD_BUILD, 8'h00, 1'b1);
        issue(CMD_BUILD, 8'h00, 1'b0);   // rebuild must not change lists
        search_text("ushers");
        search_text(" he");              // muted by leading space
        issue(CMD_SEARCH, 8'h00, 1'b1);  // muted by leading zero
        issue(CMD_SEARCH, "h", 1'b0);
        // long muted text drives the position into saturation
        issue(CMD_SEARCH, SYM_SPACE, 1'b1);
        for (int i = 0; i < 65540; i++) issue(CMD_SEARCH, "e", 1'b0);

        // random rounds, one idle setting each
        for (int rnd = 0; rnd < 4; rnd++) begin
            case (rnd)
                0: idle_pct = 0;
                1: idle_pct = 81;
                2: idle_pct = 0;
                default: idle_pct = 7;
            endcase
            repeat ($urandom_range(3, 6)) begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) issue(CMD_ADD, pick_sym(), $urandom_range(1));
                if ($urandom_range(9) != 0) issue(CMD_END, $urandom_range(255), 1'b0);
            end
            issue(CMD_END, 8'h00, 1'b0);
            issue(CMD_BUILD, $urandom_range(255), $urandom_range(1));
            for (int i = 0; i < 100; i++) begin
                n = $urandom_range(99);
                if (n < 3) begin
                    // stray command noise
                    c = $urandom_range(1);
                    issue(c, $urandom_range(255), $urandom_range(1));
                end else if (n < 6) begin
                    issue(CMD_SEARCH, $urandom_range(255), $urandom_range(1));
                end else begin
                    issue(CMD_SEARCH, pick_sym(), $urandom_range(14) == 0);
                end
            end
        end

        // state exhaustion: one long pattern runs out of trie states
        idle_pct = 0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) issue(CMD_ADD, "y", 1'b0);
        issue(CMD_END, 8'h00, 1'b0);
        issue(CMD_ADD, "x", 1'b0);
        issue(CMD_END, 8'h00, 1'b0);
        issue(CMD_BUILD, 8'h00, 1'b0);
        search_text("yyyabcdaabbhers");
        start <= 1'b0;

        // drain, then let the sequencer settle
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
